// File: hdl/mor_pkg.sv
// ----------------------------------------------------------------------------
// mor_pkg
// types and constants shared by the masked overlay recolor pipeline
// ----------------------------------------------------------------------------
package mor_pkg;

  localparam int NSTG   = 5;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [23:0] LUMA_WR    = 24'd19595;
  localparam logic [23:0] LUMA_WG    = 24'd38470;
  localparam logic [23:0] LUMA_WB    = 24'd7471;
  localparam logic [15:0] ONE88      = 16'd65280;
  localparam logic [15:0] HALF88     = 16'd32768;
  localparam logic [23:0] BRIGHT_RND = 24'd65279;
  localparam logic [7:0]  CH_MAX     = 8'd255;
  localparam logic [15:0] RCP255     = 16'd32897;
  localparam int          RCP_SH     = 23;

  typedef enum logic [1:0] {
    IDX_RED   = 2'd0,
    IDX_GREEN = 2'd1,
    IDX_BLUE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] base_alpha;
    logic [7:0] mask_level;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } res_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tgt_t;

  typedef struct packed {
    logic [NSTG-1:0] load;
    logic [NSTG-1:0] valid;
  } pipe_ctl_t;

  // floor(y / 255) for any 16-bit y up to 65279, where the quotient fits eight bits
  function automatic logic [7:0] div255(input logic [15:0] y);
    logic [31:0] p;
    p = {16'd0, y} * {16'd0, RCP255};
    return p[RCP_SH+7:RCP_SH];
  endfunction

endpackage

// File: hdl/mor_pix_if.sv
// ----------------------------------------------------------------------------
// mor_pix_if
// request channel carrying one art pixel and its mask level
// ----------------------------------------------------------------------------
interface mor_pix_if;
  import mor_pkg::*;

  logic valid;
  logic ready;
  pix_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mor_res_if.sv
// ----------------------------------------------------------------------------
// mor_res_if
// request channel carrying one recolored pixel
// ----------------------------------------------------------------------------
interface mor_res_if;
  import mor_pkg::*;

  logic valid;
  logic ready;
  res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/mor_cfg.sv
// ----------------------------------------------------------------------------
// mor_cfg
// apb register file holding the tint target color
// ----------------------------------------------------------------------------
module mor_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mor_pkg::CFG_AW-1:0]  paddr,
  input  logic [mor_pkg::CFG_DW-1:0]  pwdata,
  output logic [mor_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output mor_pkg::tgt_t               tgt
);
  import mor_pkg::*;

  tgt_t     tgt_r;
  tgt_t     tgt_nxt;
  cfg_idx_t idx;
  logic     wr;
  logic [7:0] rd_val;

  assign idx    = cfg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign tgt    = tgt_r;

  always_comb begin
    tgt_nxt = tgt_r;
    if (wr) begin
      unique case (idx)
        IDX_RED:   tgt_nxt.red   = pwdata[7:0];
        IDX_GREEN: tgt_nxt.green = pwdata[7:0];
        IDX_BLUE:  tgt_nxt.blue  = pwdata[7:0];
        default:   tgt_nxt = tgt_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      IDX_RED:   rd_val = tgt_r.red;
      IDX_GREEN: rd_val = tgt_r.green;
      IDX_BLUE:  rd_val = tgt_r.blue;
      default:   rd_val = 8'd0;
    endcase
  end

  assign prdata = {(CFG_DW - 8)'(0), rd_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
    end else begin
      tgt_r <= tgt_nxt;
    end
  end
endmodule

// File: hdl/mor_ctl.sv
// ----------------------------------------------------------------------------
// mor_ctl
// valid tracking and stage load enables for the recolor pipeline
// ----------------------------------------------------------------------------
module mor_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output logic               out_valid,
  output mor_pkg::pipe_ctl_t ctl
);
  import mor_pkg::*;

  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] valid_nxt;
  logic [NSTG-1:0] adv;
  logic [NSTG-1:0] vin;

  // a stage may take new data when empty or when its content moves on
  always_comb begin
    adv[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !valid_r[i] || adv[i+1];
    end
  end

  assign vin       = {valid_r[NSTG-2:0], in_valid};
  assign valid_nxt = (adv & vin) | (~adv & valid_r);
  assign in_ready  = adv[0];
  assign out_valid = valid_r[NSTG-1];
  assign ctl.load  = adv & vin;
  assign ctl.valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end
endmodule

// File: hdl/mor_luma.sv
// ----------------------------------------------------------------------------
// mor_luma
// first stage: 8.8 fixed point luma of the art pixel
// ----------------------------------------------------------------------------
module mor_luma (
  input  logic          clk,
  input  logic          load,
  input  mor_pkg::pix_t pix,
  output logic [15:0]   gray,
  output mor_pkg::pix_t pix_s1
);
  import mor_pkg::*;

  logic [23:0] sum;
  logic [15:0] gray_r;
  pix_t        pix_r;

  assign sum = LUMA_WR * {16'd0, pix.base_red}
             + LUMA_WG * {16'd0, pix.base_green}
             + LUMA_WB * {16'd0, pix.base_blue};

  always_ff @(posedge clk) begin
    if (load) begin
      gray_r <= sum[23:8];
      pix_r  <= pix;
    end
  end

  assign gray   = gray_r;
  assign pix_s1 = pix_r;
endmodule

// File: hdl/mor_chan.sv
// ----------------------------------------------------------------------------
// mor_chan
// stages two to five for one color channel: overlay blend, then mask mix
// ----------------------------------------------------------------------------
module mor_chan (
  input  logic               clk,
  input  mor_pkg::pipe_ctl_t ctl,
  input  logic [15:0]        gray,
  input  logic [7:0]         base,
  input  logic [7:0]         tgt,
  input  logic [7:0]         mask_s3,
  input  logic               skip_s4,
  output logic [7:0]         mix
);
  import mor_pkg::*;

  logic [14:0] a;
  logic [7:0]  b;
  logic        dark;
  logic [22:0] prod_r;
  logic        dark_s2_r;
  logic [7:0]  base_s2_r;
  logic [23:0] ysum;
  logic [7:0]  q_r;
  logic        dark_s3_r;
  logic [7:0]  base_s3_r;
  logic [7:0]  rec;
  logic [15:0] num;
  logic [15:0] num_r;
  logic [7:0]  mix_r;

  // stage 2: scaled product of luma distance and target distance
  assign dark = gray < HALF88;
  assign a    = dark ? gray[14:0] : 15'(ONE88 - gray);
  assign b    = dark ? tgt : CH_MAX - tgt;

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      prod_r    <= {8'd0, a} * {15'd0, b};
      dark_s2_r <= dark;
      base_s2_r <= base;
    end
  end

  // stage 3: divide twice the product by 65280, rounded up on the bright side
  assign ysum = {prod_r, 1'b0} + (dark_s2_r ? 24'd0 : BRIGHT_RND);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      q_r       <= div255(ysum[23:8]);
      dark_s3_r <= dark_s2_r;
      base_s3_r <= base_s2_r;
    end
  end

  // stage 4: blend numerator
  assign rec = dark_s3_r ? q_r : CH_MAX - q_r;
  assign num = {8'd0, CH_MAX - mask_s3} * {8'd0, base_s3_r} + {8'd0, mask_s3} * {8'd0, rec};

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      num_r <= num;
    end
  end

  // stage 5: divide by 255, transparent pixels give zero
  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      mix_r <= skip_s4 ? 8'd0 : div255(num_r);
    end
  end

  assign mix = mix_r;
endmodule

// File: hdl/masked_overlay_recolor.sv
// ----------------------------------------------------------------------------
// masked_overlay_recolor
// tints rgba art pixels toward a target color, weighted by a mask level
//
// in_pix carries one request per pixel (base rgba and mask level), out_res
// one recolored rgba pixel per request, in order. both use valid/ready and
// move a request at a clock edge where both are high.
// the tint color lives in three apb registers: red at 0x0, green at 0x4,
// blue at 0x8; write them only while no request is in flight.
// one pixel is taken every cycle unless a stall has filled the pipeline.
// the five stages are luma, overlay product, overlay divide, mix numerator
// and mix divide, each ending in a register.
// when out_res.ready is low the last stage holds its pixel and earlier
// stages keep filling empty slots; in_pix.ready drops once all five are full.
// a pixel with alpha zero comes out as all zeros.
// reset (rst_n low, synchronous) empties the pipeline and clears the tint
// color to black.
// ----------------------------------------------------------------------------
module masked_overlay_recolor (
  input  logic                        clk,
  input  logic                        rst_n,
  mor_pix_if.sink                     in_pix,
  mor_res_if.source                   out_res,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mor_pkg::CFG_AW-1:0]  paddr,
  input  logic [mor_pkg::CFG_DW-1:0]  pwdata,
  output logic [mor_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);
  import mor_pkg::*;

  tgt_t        tgt;
  pipe_ctl_t   ctl;
  logic [15:0] gray;
  pix_t        pix_s1;
  logic [7:0]  mask_s2_r;
  logic [7:0]  mask_s3_r;
  logic [7:0]  alpha_s2_r;
  logic [7:0]  alpha_s3_r;
  logic [7:0]  alpha_s4_r;
  logic [7:0]  alpha_s5_r;
  logic        skip_s4;

  mor_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tgt     (tgt)
  );

  mor_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .out_ready (out_res.ready),
    .out_valid (out_res.valid),
    .ctl       (ctl)
  );

  mor_luma u_luma (
    .clk    (clk),
    .load   (ctl.load[0]),
    .pix    (in_pix.data),
    .gray   (gray),
    .pix_s1 (pix_s1)
  );

  // side band: mask and alpha ride alongside the channel stages
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      mask_s2_r  <= pix_s1.mask_level;
      alpha_s2_r <= pix_s1.base_alpha;
    end
    if (ctl.load[2]) begin
      mask_s3_r  <= mask_s2_r;
      alpha_s3_r <= alpha_s2_r;
    end
    if (ctl.load[3]) begin
      alpha_s4_r <= alpha_s3_r;
    end
    if (ctl.load[4]) begin
      alpha_s5_r <= alpha_s4_r;
    end
  end

  assign skip_s4 = alpha_s4_r == 8'd0;

  mor_chan u_chan_red (
    .clk     (clk),
    .ctl     (ctl),
    .gray    (gray),
    .base    (pix_s1.base_red),
    .tgt     (tgt.red),
    .mask_s3 (mask_s3_r),
    .skip_s4 (skip_s4),
    .mix     (out_res.data.out_red)
  );

  mor_chan u_chan_green (
    .clk     (clk),
    .ctl     (ctl),
    .gray    (gray),
    .base    (pix_s1.base_green),
    .tgt     (tgt.green),
    .mask_s3 (mask_s3_r),
    .skip_s4 (skip_s4),
    .mix     (out_res.data.out_green)
  );

  mor_chan u_chan_blue (
    .clk     (clk),
    .ctl     (ctl),
    .gray    (gray),
    .base    (pix_s1.base_blue),
    .tgt     (tgt.blue),
    .mask_s3 (mask_s3_r),
    .skip_s4 (skip_s4),
    .mix     (out_res.data.out_blue)
  );

  assign out_res.data.out_alpha = alpha_s5_r;

`ifndef SYNTHESIS
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_res.valid)
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_pix.valid && in_pix.ready |=> ctl.valid[0])
    else $error("accepted pixel lost at first stage");

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.data.out_alpha == 8'd0 |->
      out_res.data.out_red == 8'd0 && out_res.data.out_green == 8'd0 &&
      out_res.data.out_blue == 8'd0)
    else $error("transparent pixel has color");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.valid == '1 && !out_res.ready |-> !in_pix.ready)
    else $error("request taken into a full pipeline");
`endif
endmodule
